### rtl/core/pidaw_pkg.sv
// Shared types, constants and fixed-point helpers for the PID controller with
// back-calculation anti-windup (signed Q16.16 arithmetic, 32-bit saturation).
// No dependencies; imported by pidaw_mul and pid_antiwindup_controller.
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

   // Fixed sample time in Q16.16 (0.01 s)
   localparam int unsigned STEP_TICKS = 655;

   // Shared multiplier operand and product widths
   localparam int unsigned MUL_W  = 33;
   localparam int unsigned PROD_W = 2 * MUL_W;

   // Wide width used for saturation of any intermediate value
   localparam int unsigned WIDE_W = 68;

   // Derivative divide: (diff * 2^16) / STEP_TICKS by reciprocal multiply.
   // |diff| at or above DIV_SAT_LIMIT always saturates; below it |diff| < 2^25,
   // so a 41-bit reciprocal leaves the estimate at most one low.
   localparam int unsigned RECIP_SHIFT   = 41;
   localparam longint unsigned RECIP_VAL = (64'd1 << RECIP_SHIFT) / STEP_TICKS;
   localparam logic [31:0] RECIP         = RECIP_VAL[31:0];
   localparam longint unsigned SAT_VAL   = 64'(STEP_TICKS) << 15;
   localparam logic [31:0] DIV_SAT_LIMIT = SAT_VAL[31:0];
   localparam logic [31:0] STEP_TICKS_32 = STEP_TICKS[31:0];

   // Q16.16 limits
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // Unity smoothing coefficient in Q1.16
   localparam logic [17:0] SMOOTH_ONE = 18'h10000;

   // Register indexes (byte address / 8)
   localparam logic [2:0] REG_KP        = 3'd0;
   localparam logic [2:0] REG_KI        = 3'd1;
   localparam logic [2:0] REG_KD        = 3'd2;
   localparam logic [2:0] REG_KB        = 3'd3;
   localparam logic [2:0] REG_KFF       = 3'd4;
   localparam logic [2:0] REG_MODE      = 3'd5;
   localparam logic [2:0] REG_OUT_LIM   = 3'd6;
   localparam logic [2:0] REG_INTEG_LIM = 3'd7;

   // Mode register bit positions
   localparam int unsigned MODE_CLAMP_I = 17;
   localparam int unsigned MODE_CLAMP_O = 18;
   localparam int unsigned MODE_BACKCALC = 19;
   localparam int unsigned MODE_FF      = 20;

   // Reset values
   localparam logic [20:0] MODE_RESET   = 21'h10000;
   localparam logic [63:0] LIMIT_RESET  = 64'h7FFF_FFFF_8000_0000;

   // Sequencer states, one-hot
   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_ERRDT  = 16'h0002,
      ST_INTEG  = 16'h0004,
      ST_QEST   = 16'h0008,
      ST_QFIX   = 16'h0010,
      ST_PTERM  = 16'h0020,
      ST_SMOOTH = 16'h0040,
      ST_DERIV  = 16'h0080,
      ST_ITERM  = 16'h0100,
      ST_DTERM  = 16'h0200,
      ST_FFTERM = 16'h0400,
      ST_OUTSUM = 16'h0800,
      ST_BCDIFF = 16'h1000,
      ST_TRACK  = 16'h2000,
      ST_BCUPD  = 16'h4000,
      ST_RESP   = 16'h8000
   } state_type;

   // Saturate a wide signed value to Q16.16
   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v > WIDE_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < WIDE_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product: floor shift by 16, then saturate
   function automatic logic signed [31:0] qm(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] sh;
      sh = p >>> 16;
      return sat32(WIDE_W'(sh));
   endfunction

   // Clamp, lower bound tested first
   function automatic logic signed [31:0] clamp(input logic signed [31:0] x,
                                                input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
      logic signed [31:0] r;
      if (x < lo) begin
         r = lo;
      end else if (x > hi) begin
         r = hi;
      end else begin
         r = x;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/pid_antiwindup_controller.sv
// PID controller step in signed Q16.16 with integral clamp, derivative
// smoothing, feed-forward, back-calculation anti-windup and output clamp.
// One request at a time: a new request is taken only in the idle state, after
// the previous result has been registered; the sequencer issues the single
// shared 33x33 multiplier from its states in turn.
// A clear request zeroes the history and gives no result. Synchronous reset
// restores register defaults and zeroes the integral and error history.
`timescale 1ns / 1ps
`default_nettype none

module pid_antiwindup_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic signed [31:0] req_setpoint,
   input  wire logic signed [31:0] req_measurement,
   input  wire logic signed [31:0] req_disturbance,
   // Result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_effort,
   // Register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [5:0]         paddr,
   input  wire logic [63:0]        pwdata,
   output logic [63:0]             prdata,
   output logic                    pready
);
   import pidaw_pkg::*;

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   logic signed [31:0] kp_ff, ki_ff, kd_ff, kb_ff, kff_ff;
   logic [20:0]        mode_ff;
   logic [63:0]        out_lim_ff, integ_lim_ff;
   logic [2:0]         reg_idx;
   logic               csr_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         kb_ff        <= '0;
         kff_ff       <= '0;
         mode_ff      <= MODE_RESET;
         out_lim_ff   <= LIMIT_RESET;
         integ_lim_ff <= LIMIT_RESET;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_KP:        kp_ff        <= pwdata[31:0];
            REG_KI:        ki_ff        <= pwdata[31:0];
            REG_KD:        kd_ff        <= pwdata[31:0];
            REG_KB:        kb_ff        <= pwdata[31:0];
            REG_KFF:       kff_ff       <= pwdata[31:0];
            REG_MODE:      mode_ff      <= pwdata[20:0];
            REG_OUT_LIM:   out_lim_ff   <= pwdata;
            REG_INTEG_LIM: integ_lim_ff <= pwdata;
            default:       ;
         endcase
      end
   end

   // Read-back
   always_comb begin
      case (reg_idx)
         REG_KP:        prdata = {32'b0, kp_ff};
         REG_KI:        prdata = {32'b0, ki_ff};
         REG_KD:        prdata = {32'b0, kd_ff};
         REG_KB:        prdata = {32'b0, kb_ff};
         REG_KFF:       prdata = {32'b0, kff_ff};
         REG_MODE:      prdata = {43'b0, mode_ff};
         REG_OUT_LIM:   prdata = out_lim_ff;
         REG_INTEG_LIM: prdata = integ_lim_ff;
         default:       prdata = '0;
      endcase
   end

   // Decoded fields
   logic [16:0]        smooth;
   logic               clamp_i, clamp_o, back_calc, ff_en;
   logic signed [31:0] omin, omax, imin, imax;

   assign smooth    = mode_ff[16:0];
   assign clamp_i   = mode_ff[MODE_CLAMP_I];
   assign clamp_o   = mode_ff[MODE_CLAMP_O];
   assign back_calc = mode_ff[MODE_BACKCALC];
   assign ff_en     = mode_ff[MODE_FF];
   assign omin      = out_lim_ff[31:0];
   assign omax      = out_lim_ff[63:32];
   assign imin      = integ_lim_ff[31:0];
   assign imax      = integ_lim_ff[63:32];

   // ---------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------
   state_type          state_ff, state_in;
   logic signed [31:0] integ_ff, last_err_ff, last_der_ff;   // controller state
   logic signed [31:0] err_ff, dist_ff;
   logic [31:0]        dabs_ff;
   logic               dneg_ff, dbig_ff;
   logic [31:0]        qest_ff;
   logic signed [31:0] raw_ff;
   logic signed [51:0] dacc_ff;
   logic signed [34:0] acc_ff;
   logic signed [31:0] out_ff, tk_ff, bc_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_effort_ff;

   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;

   logic               req_acc;
   logic               rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_effort = rsp_effort_ff;

   // Shared multiplier
   pidaw_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Combinational helpers used by single states
   logic signed [31:0] diff;
   logic signed [31:0] pterm;
   logic signed [31:0] integ_step;
   logic [47:0]        rem;
   logic [31:0]        qfix;
   logic signed [17:0] smooth_rest;
   logic signed [52:0] dsum;
   logic signed [31:0] out_clamped;

   assign diff        = sat32(WIDE_W'(err_ff) - WIDE_W'(last_err_ff));
   assign pterm       = qm(prod);
   assign integ_step  = sat32(WIDE_W'(integ_ff) + WIDE_W'(pterm));
   assign rem         = {dabs_ff, 16'b0} - prod[47:0];
   assign qfix        = qest_ff + 32'((rem >= 48'(STEP_TICKS_32)) ? 1 : 0);
   assign smooth_rest = $signed(SMOOTH_ONE) - $signed({1'b0, smooth});
   assign dsum        = 53'(dacc_ff) + 53'($signed(prod[51:0]));
   assign out_clamped = clamp(out_ff, omin, omax);

   // Multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_ERRDT: begin
            op_a = MUL_W'(err_ff);
            op_b = MUL_W'(STEP_TICKS_32);
         end
         ST_INTEG: begin
            op_a = {1'b0, dabs_ff};
            op_b = {1'b0, RECIP};
         end
         ST_QEST: begin
            op_a = {1'b0, prod[56:25]};
            op_b = MUL_W'(STEP_TICKS_32);
         end
         ST_QFIX: begin
            op_a = MUL_W'(kp_ff);
            op_b = MUL_W'(err_ff);
         end
         ST_PTERM: begin
            op_a = MUL_W'({1'b0, smooth});
            op_b = MUL_W'(raw_ff);
         end
         ST_SMOOTH: begin
            op_a = MUL_W'(smooth_rest);
            op_b = MUL_W'(last_der_ff);
         end
         ST_DERIV: begin
            op_a = MUL_W'(ki_ff);
            op_b = MUL_W'(integ_ff);
         end
         ST_ITERM: begin
            op_a = MUL_W'(kd_ff);
            op_b = MUL_W'(last_der_ff);
         end
         ST_DTERM: begin
            op_a = MUL_W'(kff_ff);
            op_b = MUL_W'(dist_ff);
         end
         ST_FFTERM: begin
            op_a = MUL_W'(STEP_TICKS_32);
            op_b = MUL_W'(ki_ff);
         end
         ST_BCDIFF: begin
            op_a = MUL_W'(tk_ff);
            op_b = MUL_W'(err_ff);
         end
         ST_TRACK: begin
            op_a = MUL_W'(kb_ff);
            op_b = MUL_W'(bc_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_acc && !req_type) state_in = ST_ERRDT;
         ST_ERRDT:  state_in = ST_INTEG;
         ST_INTEG:  state_in = ST_QEST;
         ST_QEST:   state_in = ST_QFIX;
         ST_QFIX:   state_in = ST_PTERM;
         ST_PTERM:  state_in = ST_SMOOTH;
         ST_SMOOTH: state_in = ST_DERIV;
         ST_DERIV:  state_in = ST_ITERM;
         ST_ITERM:  state_in = ST_DTERM;
         ST_DTERM:  state_in = ST_FFTERM;
         ST_FFTERM: state_in = ST_OUTSUM;
         ST_OUTSUM: state_in = ST_BCDIFF;
         ST_BCDIFF: state_in = ST_TRACK;
         ST_TRACK:  state_in = ST_BCUPD;
         ST_BCUPD:  state_in = ST_RESP;
         ST_RESP:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control state and controller history
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
         last_der_ff  <= '0;
      end else begin
         state_ff <= state_in;

         // Result register handshake
         if (state_ff == ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Clear request zeroes the history
         if (req_acc && req_type) begin
            integ_ff    <= '0;
            last_err_ff <= '0;
            last_der_ff <= '0;
         end

         case (state_ff)
            // integral += err * Ts, optional clamp; error history moves on
            ST_INTEG: begin
               integ_ff    <= clamp_i ? clamp(integ_step, imin, imax) : integ_step;
               last_err_ff <= err_ff;
            end
            // smoothed derivative
            ST_DERIV: begin
               last_der_ff <= sat32(WIDE_W'(dsum >>> 16));
            end
            // back-calculation tracking
            ST_BCUPD: begin
               if (back_calc) begin
                  integ_ff <= sat32(WIDE_W'(integ_ff) + WIDE_W'(tk_ff) + WIDE_W'(pterm));
               end
            end
            default: ;
         endcase
      end
   end

   // Payload and intermediate registers
   always_ff @(posedge clock) begin
      // capture request
      if (req_acc) begin
         err_ff  <= sat32(WIDE_W'(req_setpoint) - WIDE_W'(req_measurement));
         dist_ff <= req_disturbance;
      end

      case (state_ff)
         // error delta, split into magnitude, sign and saturation flag
         ST_ERRDT: begin
            dneg_ff <= diff[31];
            dabs_ff <= diff[31] ? (~diff + 32'd1) : diff;
            dbig_ff <= ((diff[31] ? (~diff + 32'd1) : diff) >= DIV_SAT_LIMIT);
         end
         // quotient estimate from the reciprocal product
         ST_QEST: begin
            qest_ff <= prod[56:25];
         end
         // correct the estimate, apply sign and saturation
         ST_QFIX: begin
            if (dbig_ff) begin
               raw_ff <= dneg_ff ? Q_MIN : Q_MAX;
            end else begin
               raw_ff <= dneg_ff ? (-$signed(qfix)) : $signed(qfix);
            end
         end
         ST_PTERM: begin
            acc_ff <= 35'(pterm);
         end
         ST_SMOOTH: begin
            dacc_ff <= prod[51:0];
         end
         ST_ITERM, ST_DTERM: begin
            acc_ff <= acc_ff + 35'(pterm);
         end
         ST_FFTERM: begin
            acc_ff <= acc_ff + (ff_en ? 35'(pterm) : 35'sd0);
         end
         // output before clamp; first factor of the tracking term
         ST_OUTSUM: begin
            out_ff <= sat32(WIDE_W'(acc_ff));
            tk_ff  <= pterm;
         end
         ST_BCDIFF: begin
            bc_ff <= sat32(WIDE_W'(out_clamped) - WIDE_W'(out_ff));
         end
         ST_TRACK: begin
            tk_ff <= pterm;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_effort_ff <= clamp_o ? out_clamped : out_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/pidaw_mul.sv
// Shared signed 33x33 multiplier with a registered 66-bit product.
// Depends on pidaw_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_mul (
   input  wire logic                                 clock,
   input  wire logic signed [pidaw_pkg::MUL_W-1:0]   op_a,
   input  wire logic signed [pidaw_pkg::MUL_W-1:0]   op_b,
   output logic signed [pidaw_pkg::PROD_W-1:0]       prod
);
   import pidaw_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Full-precision product
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for pid_antiwindup_controller: directed and random PID requests with bursty
// input and stalling output, each effort checked against a Q16.16 shadow of the controller.
// Depends on pidaw_pkg and the controller RTL; register writes are read back over APB.
module tb_top;
   import pidaw_pkg::*;

   localparam logic REQ_COMPUTE = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;
   localparam longint SAMPLE_TS = STEP_TICKS;
   localparam int unsigned RANDOM_PHASES = 15;
   localparam int unsigned PHASE_REQUESTS = 100;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned TIMEOUT_NS = 40_000_000;

   // Shadow of the controller: registers, loop state and efforts still owed
   class pid_shadow;
      longint kp, ki, kd, kb, kff;
      logic [20:0] mode;
      logic [63:0] out_lim, integ_lim;
      longint integ, prev_err, prev_deriv;
      logic [31:0] effort_q[$];
      int unsigned failures;

      function new();
         kp = 0; ki = 0; kd = 0; kb = 0; kff = 0;
         mode = MODE_RESET;
         out_lim = LIMIT_RESET;
         integ_lim = LIMIT_RESET;
         integ = 0; prev_err = 0; prev_deriv = 0;
         failures = 0;
      endfunction

      static function longint limit32(longint v);
         if (v > longint'(Q_MAX)) return longint'(Q_MAX);
         if (v < longint'(Q_MIN)) return longint'(Q_MIN);
         return v;
      endfunction

      // Q16.16 product, floored, saturated
      static function longint fixmul(longint a, longint b);
         return limit32((a * b) >>> 16);
      endfunction

      // Low bound is tested first, so inverted limits favor the minimum
      static function longint bound(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] value);
         case (idx)
            REG_KP: kp = longint'($signed(value[31:0]));
            REG_KI: ki = longint'($signed(value[31:0]));
            REG_KD: kd = longint'($signed(value[31:0]));
            REG_KB: kb = longint'($signed(value[31:0]));
            REG_KFF: kff = longint'($signed(value[31:0]));
            REG_MODE: mode = value[20:0];
            REG_OUT_LIM: out_lim = value;
            REG_INTEG_LIM: integ_lim = value;
            default: ;
         endcase
      endfunction

      // One controller step per accepted request
      function void apply_request(logic rtype, logic [31:0] sp_in, logic [31:0] meas_in,
                                  logic [31:0] dstb_in);
         longint sp, meas, dstb, err, s, raw, deriv, uff, outv, oc, tk, bc;
         longint omin, omax, imin, imax;
         if (rtype == REQ_CLEAR) begin
            integ = 0;
            prev_err = 0;
            prev_deriv = 0;
            return;
         end
         sp = longint'($signed(sp_in));
         meas = longint'($signed(meas_in));
         dstb = longint'($signed(dstb_in));
         s = longint'(mode[16:0]);
         omin = longint'($signed(out_lim[31:0]));
         omax = longint'($signed(out_lim[63:32]));
         imin = longint'($signed(integ_lim[31:0]));
         imax = longint'($signed(integ_lim[63:32]));

         err = limit32(sp - meas);
         integ = limit32(integ + fixmul(err, SAMPLE_TS));
         if (mode[MODE_CLAMP_I]) integ = bound(integ, imin, imax);

         // derivative: divide truncates toward zero, smoothing floors
         raw = limit32(limit32(err - prev_err) * 65536 / SAMPLE_TS);
         deriv = limit32((s * raw + (65536 - s) * prev_deriv) >>> 16);

         if (mode[MODE_FF]) uff = fixmul(kff, dstb);
         else uff = 0;
         outv = limit32(fixmul(kp, err) + fixmul(ki, integ) + fixmul(kd, deriv) + uff);

         // back-calculation uses the unclamped output
         if (mode[MODE_BACKCALC]) begin
            oc = bound(outv, omin, omax);
            tk = fixmul(fixmul(SAMPLE_TS, ki), err);
            bc = fixmul(kb, limit32(oc - outv));
            integ = limit32(integ + tk + bc);
         end
         if (mode[MODE_CLAMP_O]) outv = bound(outv, omin, omax);

         prev_err = err;
         prev_deriv = deriv;
         effort_q.push_back(outv[31:0]);
      endfunction

      function void check_effort(logic [31:0] actual);
         logic [31:0] want;
         if (effort_q.size() == 0) begin
            $error("effort: expected none, actual %0d", $signed(actual));
            failures++;
            return;
         end
         want = effort_q.pop_front();
         if (actual !== want) begin
            $error("effort: expected %0d, actual %0d", $signed(want), $signed(actual));
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = REQ_COMPUTE;
   logic [31:0] req_setpoint = '0;
   logic [31:0] req_measurement = '0;
   logic [31:0] req_disturbance = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_effort;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [5:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;

   pid_shadow shadow;
   int unsigned burst_left = 0;

   pid_antiwindup_controller i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_setpoint(req_setpoint),
      .req_measurement(req_measurement),
      .req_disturbance(req_disturbance),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_effort(rsp_effort),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.check_effort(rsp_effort);
   end

   // Receiver stall pattern; some segments hold off long enough to back up the input
   initial begin : rsp_pattern
      int unsigned seg, pick, len, stall_len, n;
      seg = 0;
      forever begin
         pick = $urandom_range(0, 18);
         if (seg % 48 == 12) begin
            repeat (HOLD_OFF_CYCLES) begin
               @(posedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            len = $urandom_range(16, 96);
            stall_len = $urandom_range(1, 40);
            for (n = 0; n < len; n++) begin
               @(posedge clock);
               if (pick <= 5) rsp_ready <= 1'b1;
               else if (pick <= 11) rsp_ready <= 1'($urandom_range(0, 1));
               else if (pick <= 16) rsp_ready <= ($urandom_range(0, 3) == 0);
               else rsp_ready <= (n >= stall_len);
            end
         end
         seg++;
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb_top: FAIL");
      $finish;
   end

   // One APB transfer; bus returns to idle afterwards
   task automatic csr_access(input logic wr, input logic [2:0] idx, input logic [63:0] wdata,
                             output logic [63:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 3'b000};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write_check(input logic [2:0] idx, input logic [63:0] value);
      logic [63:0] rd, mask;
      if (idx == REG_MODE) mask = 64'h1F_FFFF;
      else if (idx == REG_OUT_LIM || idx == REG_INTEG_LIM) mask = 64'hFFFF_FFFF_FFFF_FFFF;
      else mask = 64'hFFFF_FFFF;
      csr_access(1'b1, idx, value, rd);
      shadow.write_reg(idx, value);
      csr_access(1'b0, idx, '0, rd);
      if ((rd & mask) !== (value & mask)) begin
         $error("csr register %0d: expected %h, actual %h", idx, value & mask, rd & mask);
         shadow.failures++;
      end
   endtask

   task automatic load_config(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [31:0] kb,
                              input logic [31:0] kff, input logic [20:0] mode,
                              input logic [63:0] olim, input logic [63:0] ilim);
      csr_write_check(REG_KP, {32'h0, kp});
      csr_write_check(REG_KI, {32'h0, ki});
      csr_write_check(REG_KD, {32'h0, kd});
      csr_write_check(REG_KB, {32'h0, kb});
      csr_write_check(REG_KFF, {32'h0, kff});
      csr_write_check(REG_MODE, {43'h0, mode});
      csr_write_check(REG_OUT_LIM, olim);
      csr_write_check(REG_INTEG_LIM, ilim);
   endtask

   // Offer one request in bursts with random gaps, note it when accepted
   task automatic send_request(input logic rtype, input logic [31:0] sp,
                               input logic [31:0] meas, input logic [31:0] dstb);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end
      burst_left--;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rtype;
      req_setpoint <= sp;
      req_measurement <= meas;
      req_disturbance <= dstb;
      do @(posedge clock); while (!req_ready);
      shadow.apply_request(rtype, sp, meas, dstb);
   endtask

   // Wait until every effort is back, with the request line held low
   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.effort_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         6: return 32'h7FFF_FFFF;
         7: return 32'h8000_0000;
         8, 9: return $urandom;
         default: return 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
      endcase
   endfunction

   function automatic logic [20:0] pick_mode();
      logic [16:0] s;
      case ($urandom_range(0, 5))
         0: s = 17'h0;
         1: s = 17'h1_0000;
         2: s = 17'h1_FFFF;
         default: s = 17'($urandom_range(0, 131071));
      endcase
      return {4'($urandom_range(0, 15)), s};
   endfunction

   function automatic logic [63:0] pick_limits();
      logic [31:0] hi, lo;
      hi = 32'($urandom_range(0, 64)) * 32'h1_0000 + 32'($urandom_range(0, 65535));
      lo = -(32'($urandom_range(0, 64)) * 32'h1_0000 + 32'($urandom_range(0, 65535)));
      case ($urandom_range(0, 7))
         0: return {lo, hi};
         1: return {32'h7FFF_FFFF, 32'h8000_0000};
         2: return {32'h8000_0000, 32'h7FFF_FFFF};
         3: return {$urandom, $urandom};
         default: return {hi, lo};
      endcase
   endfunction

   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 9))
         5: return 32'h7FFF_FFFF;
         6: return 32'h8000_0000;
         7, 8, 9: return $urandom;
         default: return 32'($urandom_range(0, 32'h28_0000)) - 32'h14_0000;
      endcase
   endfunction

   // Mostly tracking traffic (measurement near setpoint), some noise and clears
   task automatic send_random_request();
      logic [31:0] sp, meas, dstb;
      logic rtype;
      rtype = ($urandom_range(0, 19) == 0) ? REQ_CLEAR : REQ_COMPUTE;
      sp = pick_level();
      if ($urandom_range(0, 9) < 6) meas = sp + (32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
      else meas = pick_level();
      dstb = pick_level();
      send_request(rtype, sp, meas, dstb);
   endtask

   initial begin : main_seq
      logic [20:0] mode_bits;
      int unsigned ph, n;
      shadow = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Everything on, moderate gains, +-10 output and +-5 integral limits
      mode_bits = 21'h0_8000;
      mode_bits[MODE_CLAMP_I] = 1'b1;
      mode_bits[MODE_CLAMP_O] = 1'b1;
      mode_bits[MODE_BACKCALC] = 1'b1;
      mode_bits[MODE_FF] = 1'b1;
      load_config(32'h1_0000, 32'h8000, 32'h4000, 32'h1_0000, 32'h2_0000, mode_bits,
                  {32'h000A_0000, 32'hFFF6_0000}, {32'h0005_0000, 32'hFFFB_0000});
      send_request(REQ_COMPUTE, 32'h0, 32'h0, 32'h0);
      send_request(REQ_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(REQ_COMPUTE, 32'h1_0000, 32'h8000, 32'h0);
      send_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
      send_request(REQ_COMPUTE, 32'h1_0000, 32'h0, 32'h8000_0000);
      send_request(REQ_COMPUTE, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
      send_request(REQ_COMPUTE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(REQ_COMPUTE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(REQ_CLEAR, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000);
      send_request(REQ_COMPUTE, 32'h3_0000, 32'h0, 32'h1_0000);
      send_request(REQ_COMPUTE, 32'h3_0000, 32'h0, 32'h1_0000);
      drain();

      // Inverted limits, extreme gains, largest smoothing field value, no feed-forward
      mode_bits = 21'h1_FFFF;
      mode_bits[MODE_CLAMP_I] = 1'b1;
      mode_bits[MODE_CLAMP_O] = 1'b1;
      mode_bits[MODE_BACKCALC] = 1'b1;
      load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  mode_bits, {32'hFFFF_0000, 32'h0001_0000}, {32'hFFFE_0000, 32'h0002_0000});
      send_request(REQ_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(REQ_COMPUTE, 32'h0, 32'h0, 32'h0);
      send_request(REQ_COMPUTE, 32'h100, 32'h0, 32'h0);
      send_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
      send_request(REQ_COMPUTE, 32'h0, 32'h100, 32'h8000_0000);
      send_request(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      send_request(REQ_COMPUTE, 32'h1, 32'h0, 32'h1);
      drain();

      // Zero smoothing, every option off
      load_config(32'h2_0000, 32'hFFFF_0000, 32'h1_8000, 32'h1_0000, 32'h3_0000, 21'h0,
                  {32'h7FFF_FFFF, 32'h8000_0000}, {32'h0010_0000, 32'hFFF0_0000});
      send_request(REQ_COMPUTE, 32'h2_0000, 32'h1_0000, 32'h7FFF_FFFF);
      send_request(REQ_COMPUTE, 32'h0, 32'h1_0000, 32'h0);
      send_request(REQ_COMPUTE, 32'h4_0000, 32'h0, 32'h0);
      send_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
      send_request(REQ_COMPUTE, 32'hFFFF_0000, 32'h0, 32'h8000_0000);
      drain();

      // Random settings, random requests
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                     pick_mode(), pick_limits(), pick_limits());
         for (n = 0; n < PHASE_REQUESTS; n++) send_random_request();
         drain();
      end

      if (shadow.failures == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
